// ===== src/bcv4_pkg.sv =====
// ----------------------------------------------------------------------------
// bcv4_pkg
// Shared types and register map of the streaming 4x4 binary convolution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcv4_pkg;

  localparam int TAPS       = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic [TAPS-1:0] window_t;
  typedef logic signed [5:0] conv_t;

  typedef enum logic [1:0] {
    REG_KERNEL = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_index_t;

endpackage

`default_nettype wire

// ===== src/bcv4_dot.sv =====
// ----------------------------------------------------------------------------
// bcv4_dot
// Signed dot product of a binary 4x4 window with the binary kernel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcv4_dot
  import bcv4_pkg::*;
(
  input  window_t window,
  input  window_t kernel,
  output conv_t   conv
);

  window_t    diff;
  logic [4:0] mismatches;
  logic [5:0] twice;

  assign diff       = window ^ kernel;
  assign mismatches = 5'($countones(diff));
  assign twice      = {mismatches, 1'b0};
  assign conv       = conv_t'(6'd16 - twice);

endmodule

`default_nettype wire

// ===== src/binary_conv4x4_stream.sv =====
// ----------------------------------------------------------------------------
// binary_conv4x4_stream
// Binarises a row-major sample stream and emits the 4x4 binary convolution.
// ----------------------------------------------------------------------------
// A sample word can be taken in every cycle unless a stalled result word holds
// the compute stage; it is registered into the compute stage, and its result
// word, if any, then into the output registers. The line store read is issued
// at acceptance and its registered data is used in the single compute stage.
// Synchronous reset clears the counters, window and control registers; the
// line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module binary_conv4x4_stream
  import bcv4_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire logic signed [15:0]    sample,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output conv_t                      conv_value,
  output logic [11:0]                window_row,
  output logic [11:0]                window_col,
  output logic                       last_window
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  window_t     kernel_signs;
  logic [12:0] image_width;
  logic [12:0] image_height;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  window_t       window_bits;
  window_t       window_next;

  logic [2:0] sign_line_store [MAX_WIDTH];
  logic [2:0] line_rdata;

  logic          s1_valid;
  logic          s1_sign;
  logic          s1_emit;
  logic          s1_last;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;

  logic [15:0]   width_clamp;
  logic [15:0]   height_clamp;
  logic [CW-1:0] width_last;
  logic [RW-1:0] height_last;
  logic          accept;
  logic          advance;
  logic          cfg_write;
  conv_t         conv;
  logic [RW-1:0] top_row;
  logic [CW-1:0] left_col;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_signs <= '0;
      image_width  <= 13'd4096;
      image_height <= 13'd4096;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_KERNEL: kernel_signs <= pwdata[15:0];
        REG_WIDTH:  image_width  <= pwdata[12:0];
        REG_HEIGHT: image_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KERNEL: prdata = {16'd0, kernel_signs};
      REG_WIDTH:  prdata = {19'd0, image_width};
      REG_HEIGHT: prdata = {19'd0, image_height};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    width_clamp = 16'(image_width);
    if (width_clamp < 16'd4) begin
      width_clamp = 16'd4;
    end else if (width_clamp > 16'(MAX_WIDTH)) begin
      width_clamp = 16'(MAX_WIDTH);
    end
    height_clamp = 16'(image_height);
    if (height_clamp < 16'd4) begin
      height_clamp = 16'd4;
    end else if (height_clamp > 16'(MAX_HEIGHT)) begin
      height_clamp = 16'(MAX_HEIGHT);
    end
  end

  assign width_last  = CW'(width_clamp - 16'd1);
  assign height_last = RW'(height_clamp - 16'd1);

  assign advance      = !result_valid || !result_stall;
  assign sample_stall = s1_valid && !advance;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (column_count >= width_last) begin
        column_count <= '0;
        row_count    <= (row_count >= height_last) ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sign    <= !sample[15];
      s1_col     <= column_count;
      s1_row     <= row_count;
      s1_emit    <= (row_count >= RW'(3)) && (column_count >= CW'(3));
      s1_last    <= (row_count >= height_last) && (column_count >= width_last);
      line_rdata <= sign_line_store[column_count];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      sign_line_store[s1_col] <= {s1_sign, line_rdata[2:1]};
    end
  end

  always_comb begin
    window_next     = (window_bits >> 1) & 16'h7777;
    window_next[3]  = line_rdata[0];
    window_next[7]  = line_rdata[1];
    window_next[11] = line_rdata[2];
    window_next[15] = s1_sign;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (s1_valid && advance) begin
      window_bits <= window_next;
    end
  end

  bcv4_dot u_dot (
    .window (window_next),
    .kernel (kernel_signs),
    .conv   (conv)
  );

  assign top_row  = s1_row - RW'(3);
  assign left_col = s1_col - CW'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1_emit) begin
      conv_value  <= conv;
      window_row  <= 12'(top_row);
      window_col  <= 12'(left_col);
      last_window <= s1_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/bcv4_checker.sv =====
// ----------------------------------------------------------------------------
// bcv4_checker
// Port-level checks of the streaming 4x4 binary convolution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcv4_checker
  import bcv4_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  sample_stall,
  input wire logic  result_valid,
  input wire logic  result_stall,
  input wire conv_t conv_value
);

  // The dot product of sixteen signed taps is even and bounded by sixteen.
  a_conv_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (conv_value >= -6'sd16) && (conv_value <= 6'sd16) && !conv_value[0])
    else $error("result word outside the even range -16..16");

  // The input side only waits when a result word is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("sample stall without a stalled result word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(conv_value)))
    else $error("stalled result word changed");

endmodule

bind binary_conv4x4_stream bcv4_checker u_bcv4_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .conv_value   (conv_value)
);

`default_nettype wire
